// File: hdl/three_nearest_neighbors_core_macros.svh
// Assertion macros used by the checker file of the nearest-neighbor core.
`ifndef THREE_NEAREST_NEIGHBORS_CORE_MACROS_SVH
`define THREE_NEAREST_NEIGHBORS_CORE_MACROS_SVH

// Consequence must hold in the same cycle as the antecedent.
`define TNN_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define TNN_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/tnn_pkg.sv
// Shared types and constants of the three-nearest-neighbor search core.
package tnn_pkg;

  // Default sizing of the reference store and the coordinate format.
  localparam int MAX_REFS_DEF   = 1024;
  localparam int COORD_BITS_DEF = 16;

  // Fixed field widths of the stream and configuration ports.
  localparam int INDEX_W   = 10;
  localparam int DIST_W    = 34;
  localparam int COUNT_W   = 11;
  localparam int PORT_CW   = 16;
  localparam int NUM_RANKS = 3;

  // Saturated distance, also returned for a rank with no neighbor.
  localparam logic [DIST_W-1:0] DIST_ALL_ONES = '1;

  // Operation carried in the input tuser bit.
  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  // Control of the ranking unit for one cycle.
  typedef struct packed {
    logic clear;
    logic update;
  } rank_ctrl_t;

endpackage

// File: hdl/tnn_rank.sv
// Sorted list of the three smallest distances seen during one query.
module tnn_rank import tnn_pkg::*; #(
  parameter int DIST_BITS = 36,
  parameter int TAG_BITS  = 10
) (
  input  logic                                clk,
  input  logic                                rst,
  input  rank_ctrl_t                          ctrl,
  input  logic [DIST_BITS-1:0]                cand_dist,
  input  logic [TAG_BITS-1:0]                 tag,
  output logic [NUM_RANKS-1:0][DIST_BITS-1:0] best_dist,
  output logic [NUM_RANKS-1:0][TAG_BITS-1:0]  best_tag,
  output logic [NUM_RANKS-1:0]                best_valid
);

  logic [NUM_RANKS-1:0] lt;

  // An empty rank counts as infinitely far; strict compare keeps the earlier slot on ties.
  always_comb begin
    for (int r = 0; r < NUM_RANKS; r++) begin
      lt[r] = !best_valid[r] || (cand_dist < best_dist[r]);
    end
  end

  // Occupancy of each rank moves with the entries.
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      best_valid <= '0;
    end else if (ctrl.update) begin
      if (lt[0]) begin
        best_valid <= {best_valid[1], best_valid[0], 1'b1};
      end else if (lt[1]) begin
        best_valid[2] <= best_valid[1];
        best_valid[1] <= 1'b1;
      end else if (lt[2]) begin
        best_valid[2] <= 1'b1;
      end
    end
  end

  // Insert the new candidate and push the worse entries down.
  always_ff @(posedge clk) begin
    if (ctrl.update) begin
      if (lt[0]) begin
        best_dist[2] <= best_dist[1];
        best_tag[2]  <= best_tag[1];
        best_dist[1] <= best_dist[0];
        best_tag[1]  <= best_tag[0];
        best_dist[0] <= cand_dist;
        best_tag[0]  <= tag;
      end else if (lt[1]) begin
        best_dist[2] <= best_dist[1];
        best_tag[2]  <= best_tag[1];
        best_dist[1] <= cand_dist;
        best_tag[1]  <= tag;
      end else if (lt[2]) begin
        best_dist[2] <= cand_dist;
        best_tag[2]  <= tag;
      end
    end
  end

endmodule

// File: hdl/three_nearest_neighbors_core.sv
// Top level of the three-nearest-neighbor search core.
//
// Input stream (s_axis): tuser selects the operation. A load transaction writes
// one reference point into the store slot given by ref_index and is finished in
// the cycle it is accepted; it produces no output. A query transaction compares
// the query point with store slots 0 .. ref_count-1 and returns one output
// transaction holding the three closest slots and their squared distances.
// Output stream (m_axis): one transaction per query, held in an output register.
// Configuration: cfg_we writes cfg_wdata into ref_count; write only while idle.
// Timing: a query walks the store at one memory read per cycle; each read word
// passes the read register, the absolute differences, the squares and the sum,
// then updates the ranking, and the result goes to the output register once the
// pipeline is empty. The store read port sets this rate. Loads can be accepted
// back to back while idle. The core accepts one query at a time and takes no new
// input until the running query has been handed to the output register.
// Stall: if the output register still holds an unread result when a query ends,
// the core waits until the receiver takes it.
// Reset: ref_count returns to 1 and all control state clears; the reference
// store is not cleared and its slots must be loaded before they are searched.
module three_nearest_neighbors_core import tnn_pkg::*; #(
  parameter int MAX_REFS   = MAX_REFS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // Fields from bit 0: ref_index(10), coord_x(16), coord_y(16), coord_z(16), zero pad(6).
  input  logic [63:0]        s_axis_tdata,
  // Fields from bit 0: operation(1).
  input  logic               s_axis_tuser,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // Fields from bit 0: nearest_index(10), second_index(10), third_index(10),
  // nearest_distance(34), second_distance(34), third_distance(34), zero pad(4).
  output logic [135:0]       m_axis_tdata,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_wdata
);

  localparam int AW      = $clog2(MAX_REFS);
  localparam int CW      = $clog2(MAX_REFS + 1);
  localparam int LW      = (CW > COUNT_W) ? CW : COUNT_W;
  localparam int SW      = (CW > INDEX_W) ? CW : INDEX_W;
  localparam int ENTRY_W = 3 * COORD_BITS;
  localparam int MAG_W   = COORD_BITS + 1;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int DW      = SQ_W + 2;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t state, state_next;

  logic [COUNT_W-1:0] ref_count;
  logic [CW-1:0]      scan_limit;
  logic [CW-1:0]      scan_k;

  // Input transaction fields.
  logic [INDEX_W-1:0]               ref_index;
  logic signed [PORT_CW-1:0]        coord_x, coord_y, coord_z;
  logic [2:0][COORD_BITS-1:0]       in_pt;
  logic                             in_accept, load_accept, query_accept;

  // Reference store and query point.
  logic [ENTRY_W-1:0]               ref_mem [MAX_REFS];
  logic [ENTRY_W-1:0]               rd_data;
  logic [2:0][COORD_BITS-1:0]       q_pt;
  logic                             slot_ok, rd_en;

  // Distance pipeline.
  logic                             p1_valid, p2_valid, p3_valid, p4_valid;
  logic [AW-1:0]                    p1_tag, p2_tag, p3_tag, p4_tag;
  logic [2:0][MAG_W-1:0]            p2_mag;
  logic [2:0][SQ_W-1:0]             p3_sq;
  logic [DW-1:0]                    p4_sum;
  logic                             pipe_busy, out_load;

  // Ranking results.
  rank_ctrl_t                       rank_ctrl;
  logic [NUM_RANKS-1:0][DW-1:0]     best_dist;
  logic [NUM_RANKS-1:0][AW-1:0]     best_tag;
  logic [NUM_RANKS-1:0]             best_valid;
  logic [NUM_RANKS-1:0][INDEX_W-1:0] res_index;
  logic [NUM_RANKS-1:0][DIST_W-1:0]  res_dist;

  // Unpack the input transaction; the low coordinate bits are kept, sign-extended.
  assign ref_index = s_axis_tdata[9:0];
  assign coord_x   = s_axis_tdata[25:10];
  assign coord_y   = s_axis_tdata[41:26];
  assign coord_z   = s_axis_tdata[57:42];
  assign in_pt[0]  = COORD_BITS'(coord_x);
  assign in_pt[1]  = COORD_BITS'(coord_y);
  assign in_pt[2]  = COORD_BITS'(coord_z);

  assign s_axis_tready = (state == ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign load_accept   = in_accept && (s_axis_tuser == OP_LOAD);
  assign query_accept  = in_accept && (s_axis_tuser == OP_QUERY);
  assign slot_ok       = SW'(ref_index) < SW'(MAX_REFS);

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_count <= COUNT_W'(1);
    end else if (cfg_we) begin
      ref_count <= cfg_wdata;
    end
  end

  // Sequencer: idle, walk the store, then wait for the pipeline and the output register.
  assign pipe_busy = p1_valid || p2_valid || p3_valid || p4_valid;
  assign out_load  = (state == ST_DRAIN) && !pipe_busy && (!m_axis_tvalid || m_axis_tready);
  assign rd_en     = (state == ST_SCAN) && (scan_k < scan_limit);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (query_accept) state_next = ST_SCAN;
      ST_SCAN:  if (!rd_en) state_next = ST_DRAIN;
      ST_DRAIN: if (out_load) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Scan counter and its limit, saturated to the store depth.
  always_ff @(posedge clk) begin
    if (query_accept) begin
      scan_k     <= '0;
      scan_limit <= (LW'(ref_count) > LW'(MAX_REFS)) ? CW'(MAX_REFS) : CW'(ref_count);
      q_pt       <= in_pt;
    end else if (rd_en) begin
      scan_k <= scan_k + CW'(1);
    end
  end

  // Reference store: loads and query reads never overlap, the sequencer keeps them apart.
  always_ff @(posedge clk) begin
    if (load_accept && slot_ok) begin
      ref_mem[AW'(ref_index)] <= {in_pt[2], in_pt[1], in_pt[0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= ref_mem[scan_k[AW-1:0]];
    end
  end

  // Valid bits of the distance pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      p3_valid <= 1'b0;
      p4_valid <= 1'b0;
    end else begin
      p1_valid <= rd_en;
      p2_valid <= p1_valid;
      p3_valid <= p2_valid;
      p4_valid <= p3_valid;
    end
  end

  // Distance pipeline: absolute differences, squares, then the sum.
  always_ff @(posedge clk) begin
    logic signed [MAG_W-1:0] diff;
    p1_tag <= scan_k[AW-1:0];
    p2_tag <= p1_tag;
    p3_tag <= p2_tag;
    p4_tag <= p3_tag;
    for (int c = 0; c < 3; c++) begin
      diff = MAG_W'(signed'(rd_data[c*COORD_BITS +: COORD_BITS]))
           - MAG_W'(signed'(q_pt[c]));
      p2_mag[c] <= diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
      p3_sq[c]  <= p2_mag[c] * p2_mag[c];
    end
    p4_sum <= DW'(p3_sq[0]) + DW'(p3_sq[1]) + DW'(p3_sq[2]);
  end

  // Ranking of the candidates.
  assign rank_ctrl.clear  = query_accept;
  assign rank_ctrl.update = p4_valid;

  tnn_rank #(
    .DIST_BITS (DW),
    .TAG_BITS  (AW)
  ) u_rank (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (rank_ctrl),
    .cand_dist  (p4_sum),
    .tag        (p4_tag),
    .best_dist  (best_dist),
    .best_tag   (best_tag),
    .best_valid (best_valid)
  );

  // Empty ranks report slot 0 and the all-ones distance; large distances saturate.
  always_comb begin
    for (int r = 0; r < NUM_RANKS; r++) begin
      res_index[r] = best_valid[r] ? INDEX_W'(best_tag[r]) : '0;
      if (!best_valid[r] || (best_dist[r] > DW'(DIST_ALL_ONES))) begin
        res_dist[r] = DIST_ALL_ONES;
      end else begin
        res_dist[r] = DIST_W'(best_dist[r]);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {4'b0, res_dist[2], res_dist[1], res_dist[0],
                       res_index[2], res_index[1], res_index[0]};
    end
  end

endmodule

// File: hdl/tnn_checker.sv
// Port-level checks of the nearest-neighbor core and their binding.
`include "three_nearest_neighbors_core_macros.svh"

module tnn_checker import tnn_pkg::*; (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tuser,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [135:0] m_axis_tdata,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready
);

  logic in_acc;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // A stalled result holds.
  `TNN_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata), "output result changed while stalled")

  // A load never produces a result.
  `TNN_ASSERT_NEXT(a_load_silent, clk, rst, in_acc && (s_axis_tuser == OP_LOAD) && !m_axis_tvalid,
    !m_axis_tvalid, "load transaction produced a result")

  // A query occupies the core.
  `TNN_ASSERT_NEXT(a_query_busy, clk, rst, in_acc && (s_axis_tuser == OP_QUERY),
    !s_axis_tready, "input accepted during a running query")

  // Result distances come out in ascending order.
  `TNN_ASSERT_SAME(a_sorted, clk, rst, m_axis_tvalid,
    (m_axis_tdata[63:30] <= m_axis_tdata[97:64]) && (m_axis_tdata[97:64] <= m_axis_tdata[131:98]),
    "result distances out of order")

endmodule

bind three_nearest_neighbors_core tnn_checker u_tnn_checker (.*);

// File: tb/three_nearest_neighbors_core_tb.sv
// Self-checking testbench of the three-nearest-neighbor search core.
module three_nearest_neighbors_core_tb;
  import tnn_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int IDLE_PCT    = 31;
  localparam longint NO_NEIGHBOR = 64'h7FFF_FFFF_FFFF_FFFF;

  // One point as three signed Q8.8 coordinates, x in the lowest bits.
  typedef struct packed {
    logic signed [PORT_CW-1:0] z;
    logic signed [PORT_CW-1:0] y;
    logic signed [PORT_CW-1:0] x;
  } point_t;

  // Input tdata layout, slot in the lowest bits.
  typedef struct packed {
    logic [5:0]         pad;
    point_t             pt;
    logic [INDEX_W-1:0] slot;
  } point_word_t;

  // Output tdata layout, rank 0 (nearest) in the lowest bits of each array.
  typedef struct packed {
    logic [3:0]                          pad;
    logic [NUM_RANKS-1:0][DIST_W-1:0]    rank_dist;
    logic [NUM_RANKS-1:0][INDEX_W-1:0]   idx;
  } nn_result_t;

  typedef struct {
    op_t         op;
    point_word_t word;
  } stream_item_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic [63:0]         s_axis_tdata = '0;
  logic                s_axis_tuser = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [135:0]        m_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic                cfg_we = 1'b0;
  logic [COUNT_W-1:0]  cfg_wdata = '0;

  // Stimulus waiting for the driver, and results waiting for the output.
  stream_item_t item_queue[$];
  nn_result_t   pending_results[$];

  // Predictor state: the reference store and the search length.
  point_t store_pt [MAX_REFS_DEF];
  int     search_len = 1;

  // Bookkeeping at generation time, so that no unwritten slot is searched.
  bit     slot_loaded [MAX_REFS_DEF];
  point_t plan_pt [MAX_REFS_DEF];

  bit  steady = 1'b0;
  bit  in_taken = 1'b0;
  int  cycle_count = 0;
  int  mismatch_count = 0;
  int  loads_done = 0;
  int  queries_done = 0;
  int  results_checked = 0;
  int  lengths_used = 1;

  string rank_name [NUM_RANKS] = '{"nearest", "second", "third"};

  three_nearest_neighbors_core u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit, in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic bit take_break();
    return !steady && ($urandom_range(0, 99) < IDLE_PCT);
  endfunction

  function automatic longint sq_gap(logic signed [PORT_CW-1:0] a,
                                    logic signed [PORT_CW-1:0] b);
    longint g;
    g = longint'(a) - longint'(b);
    return g * g;
  endfunction

  // Expected result of a query against the current store and search length.
  function automatic nn_result_t search_nearest(point_t q);
    longint     best [NUM_RANKS];
    int         best_idx [NUM_RANKS];
    int         span;
    longint     d;
    nn_result_t res;
    for (int r = 0; r < NUM_RANKS; r++) begin
      best[r] = NO_NEIGHBOR;
      best_idx[r] = 0;
    end
    span = (search_len > MAX_REFS_DEF) ? MAX_REFS_DEF : search_len;
    for (int k = 0; k < span; k++) begin
      d = sq_gap(store_pt[k].x, q.x) + sq_gap(store_pt[k].y, q.y)
        + sq_gap(store_pt[k].z, q.z);
      // Strict compares keep the lower slot ahead on equal distances.
      if (d < best[0]) begin
        best[2] = best[1]; best_idx[2] = best_idx[1];
        best[1] = best[0]; best_idx[1] = best_idx[0];
        best[0] = d;       best_idx[0] = k;
      end else if (d < best[1]) begin
        best[2] = best[1]; best_idx[2] = best_idx[1];
        best[1] = d;       best_idx[1] = k;
      end else if (d < best[2]) begin
        best[2] = d;       best_idx[2] = k;
      end
    end
    res = '0;
    for (int r = 0; r < NUM_RANKS; r++) begin
      res.idx[r] = best_idx[r][INDEX_W-1:0];
      if (best[r] == NO_NEIGHBOR || best[r] > longint'(DIST_ALL_ONES))
        res.rank_dist[r] = DIST_ALL_ONES;
      else
        res.rank_dist[r] = best[r][DIST_W-1:0];
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, longint expected, longint got);
    $display("MISMATCH at cycle %0d: %s expected %0d got %0d",
             cycle_count, what, expected, got);
    mismatch_count++;
  endtask

  // Prediction on input transactions and checking of output transactions.
  always @(posedge clk) begin
    point_word_t w;
    nn_result_t  got;
    nn_result_t  want;
    if (!rst) begin
      in_taken <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        w = point_word_t'(s_axis_tdata);
        if (op_t'(s_axis_tuser) == OP_LOAD) begin
          store_pt[w.slot] = w.pt;
          loads_done++;
        end else begin
          pending_results.push_back(search_nearest(w.pt));
          queries_done++;
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = nn_result_t'(m_axis_tdata);
        if (pending_results.size() == 0) begin
          report_mismatch("queries waiting for a result", 1, 0);
        end else begin
          want = pending_results.pop_front();
          results_checked++;
          for (int r = 0; r < NUM_RANKS; r++) begin
            if (got.idx[r] !== want.idx[r])
              report_mismatch({rank_name[r], " index"}, want.idx[r], got.idx[r]);
            if (got.rank_dist[r] !== want.rank_dist[r])
              report_mismatch({rank_name[r], " distance"}, want.rank_dist[r],
                              got.rank_dist[r]);
          end
        end
      end
    end
  end

  // Driver: presents queued items and holds each until it is taken.
  always @(negedge clk) begin
    stream_item_t next_item;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      m_axis_tready <= 1'b0;
    end else begin
      if (!s_axis_tvalid || in_taken) begin
        if (item_queue.size() > 0 && !take_break()) begin
          next_item = item_queue.pop_front();
          s_axis_tdata  <= next_item.word;
          s_axis_tuser  <= next_item.op;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= !take_break();
    end
  end

  // Stimulus helpers.
  function automatic logic signed [PORT_CW-1:0] rand_coord();
    case ($urandom_range(0, 7))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return PORT_CW'($urandom_range(0, 15)) - 16'sd8;
      default: return PORT_CW'($urandom);
    endcase
  endfunction

  function automatic point_t rand_point();
    point_t p;
    p.x = rand_coord();
    p.y = rand_coord();
    p.z = rand_coord();
    return p;
  endfunction

  function automatic void push_load(int slot, point_t p);
    stream_item_t it;
    it.op = OP_LOAD;
    it.word = '0;
    it.word.slot = slot[INDEX_W-1:0];
    it.word.pt = p;
    item_queue.push_back(it);
    slot_loaded[slot] = 1'b1;
    plan_pt[slot] = p;
  endfunction

  function automatic void push_query(point_t p);
    stream_item_t it;
    it.op = OP_QUERY;
    // The slot field is ignored by a query, so it carries noise.
    it.word = '0;
    it.word.slot = INDEX_W'($urandom);
    it.word.pt = p;
    item_queue.push_back(it);
  endfunction

  function automatic point_t make_point(int x, int y, int z);
    point_t p;
    p.x = x[PORT_CW-1:0];
    p.y = y[PORT_CW-1:0];
    p.z = z[PORT_CW-1:0];
    return p;
  endfunction

  // Waits until every item is taken and every result is in, plus the latency.
  task automatic wait_idle();
    while (item_queue.size() > 0 || s_axis_tvalid || pending_results.size() > 0)
      @(posedge clk);
    repeat (((search_len > MAX_REFS_DEF) ? MAX_REFS_DEF : search_len) + 8)
      @(posedge clk);
  endtask

  task automatic set_search_length(int count);
    wait_idle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= count[COUNT_W-1:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
    search_len = count;
    lengths_used++;
  endtask

  // One random phase: fill the searched slots, then mixed loads and queries.
  task automatic run_phase(int count, int num_items, int query_pct, bit no_idle);
    int     span;
    int     k;
    point_t p;
    set_search_length(count);
    steady = no_idle;
    span = (count > MAX_REFS_DEF) ? MAX_REFS_DEF : count;
    for (int s = 0; s < span; s++)
      if (!slot_loaded[s])
        push_load(s, rand_point());
    for (int n = 0; n < num_items; n++) begin
      k = (span > 0) ? $urandom_range(0, span - 1) : 0;
      if ($urandom_range(0, 99) < query_pct) begin
        case ($urandom_range(0, 3))
          0: p = (span > 0) ? plan_pt[k] : rand_point();
          1: begin
            p = (span > 0) ? plan_pt[k] : rand_point();
            p.x = p.x + PORT_CW'($urandom_range(0, 6)) - 16'sd3;
            p.z = p.z + PORT_CW'($urandom_range(0, 6)) - 16'sd3;
          end
          default: p = rand_point();
        endcase
        push_query(p);
      end else begin
        // Copies of searched points make equal distances likely.
        p = (span > 0 && $urandom_range(0, 3) == 0) ? plan_pt[k] : rand_point();
        if (span > 0 && $urandom_range(0, 2) == 0)
          push_load($urandom_range(0, span - 1), p);
        else
          push_load($urandom_range(0, MAX_REFS_DEF - 1), p);
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: search length 1 from reset, two ranks unfilled.
    push_load(0, make_point(0, 0, 0));
    push_query(make_point(32767, 32767, 32767));
    push_query(make_point(-32768, -32768, -32768));

    // Directed: zero search length leaves all ranks unfilled.
    set_search_length(0);
    push_query(make_point(0, 0, 0));

    // Directed: extreme corners and the largest possible distance.
    set_search_length(3);
    push_load(1, make_point(-32768, -32768, -32768));
    push_load(2, make_point(32767, 32767, 32767));
    push_query(make_point(-32768, -32768, -32768));
    push_query(make_point(32767, 32767, 32767));
    push_query(make_point(1, -1, 0));

    // Directed: two slots searched, third rank unfilled.
    set_search_length(2);
    push_query(make_point(100, 0, 0));

    // Directed: equal distances keep the lower slot first; top slot loaded.
    set_search_length(4);
    push_load(3, make_point(0, 0, 0));
    push_load(1023, make_point(-1, 32767, -32768));
    push_query(make_point(0, 0, 0));
    push_query(make_point(-32768, 32767, -1));
    push_query(make_point(5, 5, 5));

    // Random phases over small, large and saturated search lengths.
    run_phase(1, 40, 60, 1'b0);
    run_phase(2, 40, 60, 1'b0);
    run_phase(3, 60, 60, 1'b1);
    run_phase(0, 15, 50, 1'b0);
    run_phase($urandom_range(4, 12), 80, 60, 1'b0);
    run_phase($urandom_range(13, 64), 80, 50, 1'b0);
    run_phase($urandom_range(200, 400), 24, 40, 1'b0);
    run_phase(1024, 12, 40, 1'b0);
    run_phase(2047, 6, 50, 1'b0);
    run_phase($urandom_range(1025, 2046), 6, 50, 1'b0);
    run_phase($urandom_range(5, 40), 60, 60, 1'b0);

    wait_idle();
    while (pending_results.size() > 0) begin
      void'(pending_results.pop_front());
      report_mismatch("results arrived for a query", 1, 0);
    end

    $display("Run covered %0d loads and %0d queries over %0d search lengths (0 to 2047);",
             loads_done, queries_done, lengths_used);
    $display("%0d results checked, %0d field mismatches.", results_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
